/* hw/rtl/hbs_pkg.sv */
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared constants, register indexes and stage types of the heightfield
// bilinear sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

    localparam int MAX_CELLS_DEF = 63;
    localparam int CELL_W        = 8;
    localparam int ADDR_W        = 12;
    localparam int STORE_DEPTH   = 4096;
    localparam int SAMPLE_W      = 16;
    localparam int FRAC_W        = 17;

    localparam logic [5:0]  CELLS_RESET    = 6'd63;
    localparam logic [31:0] INV_SPC_RESET  = 32'd65536;
    localparam logic [16:0] FRAC_ONE       = 17'd65536;

    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Z    = 3'd1;
    localparam logic [2:0] REG_EXTENT      = 3'd2;
    localparam logic [2:0] REG_INV_SPACING = 3'd3;
    localparam logic [2:0] REG_CELLS       = 3'd4;
    localparam logic [2:0] REG_SCALE       = 3'd5;
    localparam logic [2:0] REG_OFFSET      = 3'd6;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Cell coordinates of one request, as handed from the grid front end.
    typedef struct packed {
        logic                valid;
        logic                query;
        logic                inb;
        logic [CELL_W-1:0]   col;
        logic [CELL_W-1:0]   row;
        logic [CELL_W:0]     row_len;
        logic [FRAC_W-1:0]   fx;
        logic [FRAC_W-1:0]   fz;
        logic [ADDR_W-1:0]   idx;
        logic [SAMPLE_W-1:0] val;
    } grid_t;

    // Request control aligned with the corner sample reads.
    typedef struct packed {
        logic              valid;
        logic              inb;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fz;
    } blend_ctl_t;

endpackage

/* hw/rtl/hbs_ram.sv */
// ----------------------------------------------------------------------------
// hbs_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module hbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/hbs_front.sv */
// ----------------------------------------------------------------------------
// hbs_front
// Three stages: offset from origin, bounds check and reciprocal multiply,
// then split into cell and fraction with far-edge clamping.
// ----------------------------------------------------------------------------
module hbs_front #(
    parameter int MAX_CELLS = hbs_pkg::MAX_CELLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic                          req_type,
    input  logic [hbs_pkg::ADDR_W-1:0]    sample_index,
    input  logic [hbs_pkg::SAMPLE_W-1:0]  sample_value,
    input  logic signed [31:0]            query_x,
    input  logic signed [31:0]            query_z,
    input  logic signed [31:0]            origin_x,
    input  logic signed [31:0]            origin_z,
    input  logic [30:0]                   extent,
    input  logic [31:0]                   inv_spacing,
    input  logic [5:0]                    cells_per_side,
    output hbs_pkg::grid_t                grid
);

    localparam logic [hbs_pkg::CELL_W-1:0] MAXC = hbs_pkg::CELL_W'(MAX_CELLS);

    // Stage 1
    logic                          s1_valid_reg;
    logic                          s1_query_reg;
    logic signed [32:0]            s1_dx_reg;
    logic signed [32:0]            s1_dz_reg;
    logic [hbs_pkg::ADDR_W-1:0]    s1_idx_reg;
    logic [hbs_pkg::SAMPLE_W-1:0]  s1_val_reg;
    // Stage 2
    logic                          s2_valid_reg;
    logic                          s2_query_reg;
    logic                          s2_inb_reg;
    logic [46:0]                   s2_gx_reg;
    logic [46:0]                   s2_gz_reg;
    logic [hbs_pkg::ADDR_W-1:0]    s2_idx_reg;
    logic [hbs_pkg::SAMPLE_W-1:0]  s2_val_reg;
    // Stage 3
    logic                          s3_valid_reg;
    hbs_pkg::grid_t                s3_reg;
    hbs_pkg::grid_t                s3_next;

    logic                          inb;
    logic [62:0]                   prod_x;
    logic [62:0]                   prod_z;
    logic [hbs_pkg::CELL_W-1:0]    cells_eff;

    assign inb = !s1_dx_reg[32] && !s1_dz_reg[32]
                 && (s1_dx_reg[31:0] <= {1'b0, extent})
                 && (s1_dz_reg[31:0] <= {1'b0, extent});
    assign prod_x = 63'(s1_dx_reg[30:0]) * 63'(inv_spacing);
    assign prod_z = 63'(s1_dz_reg[30:0]) * 63'(inv_spacing);

    always_comb
    begin
        if (cells_per_side == 6'd0)
        begin
            cells_eff = hbs_pkg::CELL_W'(1);
        end
        else if (hbs_pkg::CELL_W'(cells_per_side) > MAXC)
        begin
            cells_eff = MAXC;
        end
        else
        begin
            cells_eff = hbs_pkg::CELL_W'(cells_per_side);
        end
    end

    always_comb
    begin
        s3_next         = '0;
        s3_next.query   = s2_query_reg;
        s3_next.inb     = s2_inb_reg;
        s3_next.row_len = {1'b0, cells_eff} + 9'd1;
        s3_next.idx     = s2_idx_reg;
        s3_next.val     = s2_val_reg;
        // A cell index at or past the cell count lands on the far edge of the last cell.
        if (s2_gx_reg[46:16] >= 31'(cells_eff))
        begin
            s3_next.col = cells_eff - 8'd1;
            s3_next.fx  = hbs_pkg::FRAC_ONE;
        end
        else
        begin
            s3_next.col = s2_gx_reg[16 +: hbs_pkg::CELL_W];
            s3_next.fx  = {1'b0, s2_gx_reg[15:0]};
        end
        if (s2_gz_reg[46:16] >= 31'(cells_eff))
        begin
            s3_next.row = cells_eff - 8'd1;
            s3_next.fz  = hbs_pkg::FRAC_ONE;
        end
        else
        begin
            s3_next.row = s2_gz_reg[16 +: hbs_pkg::CELL_W];
            s3_next.fz  = {1'b0, s2_gz_reg[15:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_query_reg <= req_type;
            s1_dx_reg    <= {query_x[31], query_x} - {origin_x[31], origin_x};
            s1_dz_reg    <= {query_z[31], query_z} - {origin_z[31], origin_z};
            s1_idx_reg   <= sample_index;
            s1_val_reg   <= sample_value;
            s2_query_reg <= s1_query_reg;
            s2_inb_reg   <= inb;
            s2_gx_reg    <= prod_x[62:16];
            s2_gz_reg    <= prod_z[62:16];
            s2_idx_reg   <= s1_idx_reg;
            s2_val_reg   <= s1_val_reg;
            s3_reg       <= s3_next;
        end
    end

    always_comb
    begin
        grid       = s3_reg;
        grid.valid = s3_valid_reg;
    end

endmodule

/* hw/rtl/hbs_back.sv */
// ----------------------------------------------------------------------------
// hbs_back
// Bilinear blend along X and Z, rounding, world scaling with offset and
// saturation, and the output register.
// ----------------------------------------------------------------------------
module hbs_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  hbs_pkg::blend_ctl_t          ctl,
    input  logic [hbs_pkg::SAMPLE_W-1:0] s00,
    input  logic [hbs_pkg::SAMPLE_W-1:0] s01,
    input  logic [hbs_pkg::SAMPLE_W-1:0] s10,
    input  logic [hbs_pkg::SAMPLE_W-1:0] s11,
    input  logic [31:0]                  height_scale,
    input  logic signed [31:0]           height_offset,
    output logic                         out_valid,
    output logic signed [31:0]           height,
    output logic                         in_bounds
);

    logic                a_valid_reg;
    logic                a_inb_reg;
    logic [16:0]         a_fx_reg;
    logic [16:0]         a_fz_reg;
    logic                b_valid_reg;
    logic                b_inb_reg;
    logic [16:0]         b_fz_reg;
    logic [31:0]         b_b0_reg;
    logic [31:0]         b_b1_reg;
    logic                c_valid_reg;
    logic                c_inb_reg;
    logic [31:0]         c_hr_reg;
    logic                d_valid_reg;
    logic                d_inb_reg;
    logic [63:0]         d_prod_reg;
    logic                out_valid_reg;
    logic signed [31:0]  height_reg;
    logic                in_bounds_reg;

    logic [16:0]         wx;
    logic [16:0]         wz;
    logic [32:0]         b0;
    logic [32:0]         b1;
    logic [48:0]         h;
    logic [64:0]         scaled;
    logic signed [41:0]  world;
    logic signed [31:0]  height_next;

    assign wx = hbs_pkg::FRAC_ONE - a_fx_reg;
    assign b0 = 33'(s00) * 33'(wx) + 33'(s01) * 33'(a_fx_reg);
    assign b1 = 33'(s10) * 33'(wx) + 33'(s11) * 33'(a_fx_reg);

    assign wz = hbs_pkg::FRAC_ONE - b_fz_reg;
    assign h  = 49'(b_b0_reg) * 49'(wz) + 49'(b_b1_reg) * 49'(b_fz_reg) + 49'h8000;

    assign scaled = 65'(d_prod_reg) + 65'h80_0000;
    assign world  = $signed({1'b0, scaled[64:24]}) + 42'(height_offset);

    always_comb
    begin
        if (!d_inb_reg)
        begin
            height_next = '0;
        end
        else if (world > 42'sd2147483647)
        begin
            height_next = 32'sh7FFF_FFFF;
        end
        else if (world < -42'sd2147483648)
        begin
            height_next = 32'sh8000_0000;
        end
        else
        begin
            height_next = world[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= ctl.valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            out_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_inb_reg     <= ctl.inb;
            a_fx_reg      <= ctl.fx;
            a_fz_reg      <= ctl.fz;
            b_inb_reg     <= a_inb_reg;
            b_fz_reg      <= a_fz_reg;
            b_b0_reg      <= b0[31:0];
            b_b1_reg      <= b1[31:0];
            c_inb_reg     <= b_inb_reg;
            c_hr_reg      <= h[47:16];
            d_inb_reg     <= c_inb_reg;
            d_prod_reg    <= 64'(c_hr_reg) * 64'(height_scale);
            height_reg    <= height_next;
            in_bounds_reg <= d_inb_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign height    = height_reg;
    assign in_bounds = in_bounds_reg;

endmodule

/* hw/rtl/heightfield_bilinear_sampler.sv */
// ----------------------------------------------------------------------------
// heightfield_bilinear_sampler
// Bilinear height lookup on a square grid of 16-bit samples, scaled to world
// height. Load requests write samples; query requests return one result.
//
//   channel  handshake            payload
//   in       in_valid / in_ready  req_type, sample_index, sample_value,
//                                 query_x, query_z
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//   out      out_valid/out_ready  height, in_bounds
//
// One request is accepted per cycle while the pipeline is not held. The depth
// of a query is set by the grid front end (3 stages), the corner read (1) and
// the blend and scale multipliers (4). Loads write the four sample copies at
// the read stage and give no result.
// Reset clears control and configuration; the sample store is not cleared.
// When the output register is full and not taken, the whole pipeline holds.
// ----------------------------------------------------------------------------
module heightfield_bilinear_sampler #(
    parameter int MAX_CELLS = hbs_pkg::MAX_CELLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [hbs_pkg::ADDR_W-1:0]    sample_index,
    input  logic [hbs_pkg::SAMPLE_W-1:0]  sample_value,
    input  logic signed [31:0]            query_x,
    input  logic signed [31:0]            query_z,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            height,
    output logic                          in_bounds
);

    logic signed [31:0]            origin_x_reg;
    logic signed [31:0]            origin_z_reg;
    logic [30:0]                   extent_reg;
    logic [31:0]                   inv_spacing_reg;
    logic [5:0]                    cells_reg;
    logic [31:0]                   scale_reg;
    logic signed [31:0]            offset_reg;

    logic                          adv;
    hbs_pkg::grid_t                grid;
    hbs_pkg::blend_ctl_t           ctl;
    logic                          we;
    logic [16:0]                   base_full;
    logic [hbs_pkg::ADDR_W-1:0]    addr [4];
    logic [hbs_pkg::SAMPLE_W-1:0]  rdata [4];

    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_z_reg    <= '0;
            extent_reg      <= '0;
            inv_spacing_reg <= hbs_pkg::INV_SPC_RESET;
            cells_reg       <= hbs_pkg::CELLS_RESET;
            scale_reg       <= '0;
            offset_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                hbs_pkg::REG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                hbs_pkg::REG_ORIGIN_Z:    origin_z_reg    <= cfg_data;
                hbs_pkg::REG_EXTENT:      extent_reg      <= cfg_data[30:0];
                hbs_pkg::REG_INV_SPACING: inv_spacing_reg <= cfg_data;
                hbs_pkg::REG_CELLS:       cells_reg       <= cfg_data[5:0];
                hbs_pkg::REG_SCALE:       scale_reg       <= cfg_data;
                hbs_pkg::REG_OFFSET:      offset_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    hbs_front #(
        .MAX_CELLS (MAX_CELLS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .in_valid       (in_valid),
        .req_type       (req_type),
        .sample_index   (sample_index),
        .sample_value   (sample_value),
        .query_x        (query_x),
        .query_z        (query_z),
        .origin_x       (origin_x_reg),
        .origin_z       (origin_z_reg),
        .extent         (extent_reg),
        .inv_spacing    (inv_spacing_reg),
        .cells_per_side (cells_reg),
        .grid           (grid)
    );

    // Corner addresses wrap modulo the store depth.
    assign base_full = 17'(grid.row) * 17'(grid.row_len) + 17'(grid.col);
    assign addr[0]   = base_full[hbs_pkg::ADDR_W-1:0];
    assign addr[1]   = addr[0] + 12'd1;
    assign addr[2]   = addr[0] + 12'(grid.row_len);
    assign addr[3]   = addr[2] + 12'd1;

    assign we = adv && grid.valid && (grid.query == hbs_pkg::REQ_LOAD);

    for (genvar i = 0; i < 4; i++)
    begin : g_bank
        hbs_ram #(
            .WIDTH (hbs_pkg::SAMPLE_W),
            .DEPTH (hbs_pkg::STORE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (grid.idx),
            .wdata (grid.val),
            .re    (adv),
            .raddr (addr[i]),
            .rdata (rdata[i])
        );
    end

    always_comb
    begin
        ctl.valid = grid.valid && (grid.query == hbs_pkg::REQ_QUERY);
        ctl.inb   = grid.inb;
        ctl.fx    = grid.fx;
        ctl.fz    = grid.fz;
    end

    hbs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .ctl           (ctl),
        .s00           (rdata[0]),
        .s01           (rdata[1]),
        .s10           (rdata[2]),
        .s11           (rdata[3]),
        .height_scale  (scale_reg),
        .height_offset (offset_reg),
        .out_valid     (out_valid),
        .height        (height),
        .in_bounds     (in_bounds)
    );

endmodule

/* test/heightfield_bilinear_sampler_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightfield_bilinear_sampler_test
// Self-checking bench for the bilinear height sampler. The part of the sample
// store that the grids use is filled first. A short table of directed
// requests follows. Then come phases of random loads and queries under
// changing register settings and idle patterns. Every query result is checked
// against a fixed expected value or an in-bench predictor.
// ----------------------------------------------------------------------------
module heightfield_bilinear_sampler_test;

    typedef struct {
        logic signed [31:0] height;
        logic               inb;
    } height_result_t;

    typedef struct {
        logic               kind;
        logic [11:0]        idx;
        logic [15:0]        val;
        logic [31:0]        x;
        logic [31:0]        z;
        bit                 typed;
        logic signed [31:0] height;
        logic               inb;
    } stim_row_t;

    // Random grids stay at or below this cell count, so only the first
    // (RAND_CELLS_MAX + 1)^2 samples are ever read.
    localparam int RAND_CELLS_MAX = 15;
    localparam int FILL_DEPTH     = (RAND_CELLS_MAX + 1) * (RAND_CELLS_MAX + 1);

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic                         req_type = hbs_pkg::REQ_LOAD;
    logic [hbs_pkg::ADDR_W-1:0]   sample_index = '0;
    logic [hbs_pkg::SAMPLE_W-1:0] sample_value = '0;
    logic signed [31:0]           query_x = '0;
    logic signed [31:0]           query_z = '0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [2:0]                   cfg_index = hbs_pkg::REG_ORIGIN_X;
    logic [31:0]                  cfg_data = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic signed [31:0]           height;
    logic                         in_bounds;

    // Predictor state: configuration and a copy of the sample store.
    logic signed [31:0]  org_x, org_z;
    logic [30:0]         side_len;
    logic [31:0]         inv_spc;
    logic [5:0]          cell_cnt;
    logic [31:0]         h_scale;
    logic signed [31:0]  h_offset;
    logic [15:0]         sample_mem [hbs_pkg::STORE_DEPTH];

    height_result_t      pending_heights [$];
    int                  err_cnt = 0;
    int                  send_pct = 0;
    int                  recv_pct = 0;
    int                  hold_req = 0;
    int                  hold_ack = 0;
    int                  hold_left = 0;

    heightfield_bilinear_sampler DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .sample_index (sample_index),
        .sample_value (sample_value),
        .query_x      (query_x),
        .query_z      (query_z),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .height       (height),
        .in_bounds    (in_bounds)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void grid_coord(input longint unsigned d, input longint unsigned cells,
                                       output longint unsigned cell_num,
                                       output longint unsigned frac);
        longint unsigned g;
        g = (d * longint'(inv_spc)) >> 16;
        cell_num = g >> 16;
        frac = g & 64'hFFFF;
        if (cell_num >= cells)
        begin
            cell_num = cells - 1;
            frac = 65536;
        end
    endfunction

    function automatic height_result_t predict_height(input logic [31:0] x, input logic [31:0] z);
        height_result_t  r;
        longint          dx, dz, world;
        longint unsigned cells, row_len, col, row, fx, fz, base;
        longint unsigned s00, s01, s10, s11, b0, b1, h, hr, scaled;
        dx = longint'($signed(x)) - longint'(org_x);
        dz = longint'($signed(z)) - longint'(org_z);
        r.height = '0;
        r.inb = 1'b0;
        if (dx < 0 || dz < 0 || dx > longint'(side_len) || dz > longint'(side_len))
            return r;
        cells = cell_cnt;
        if (cells < 1)
            cells = 1;
        if (cells > hbs_pkg::MAX_CELLS_DEF)
            cells = hbs_pkg::MAX_CELLS_DEF;
        row_len = cells + 1;
        grid_coord(dx, cells, col, fx);
        grid_coord(dz, cells, row, fz);
        base = row * row_len + col;
        s00 = sample_mem[base % hbs_pkg::STORE_DEPTH];
        s01 = sample_mem[(base + 1) % hbs_pkg::STORE_DEPTH];
        s10 = sample_mem[(base + row_len) % hbs_pkg::STORE_DEPTH];
        s11 = sample_mem[(base + row_len + 1) % hbs_pkg::STORE_DEPTH];
        b0 = s00 * (65536 - fx) + s01 * fx;
        b1 = s10 * (65536 - fx) + s11 * fx;
        h = b0 * (65536 - fz) + b1 * fz;
        hr = (h + 64'h8000) >> 16;
        scaled = (hr * longint'(h_scale) + 64'h800000) >> 24;
        world = longint'(scaled) + longint'(h_offset);
        if (world > 64'sd2147483647)
            world = 64'sd2147483647;
        if (world < -64'sd2147483648)
            world = -64'sd2147483648;
        r.height = world[31:0];
        r.inb = 1'b1;
        return r;
    endfunction

    // Offers one request and returns at the edge where it was taken.
    task automatic send_request(input logic kind, input logic [11:0] idx, input logic [15:0] val,
                                input logic [31:0] x, input logic [31:0] z,
                                input bit typed, input height_result_t typed_res);
        if ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_pct);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        sample_index <= idx;
        sample_value <= val;
        query_x <= x;
        query_z <= z;
        do
            @(posedge clk);
        while (!in_ready);
        if (kind == hbs_pkg::REQ_LOAD)
            sample_mem[idx] = val;
        else if (typed)
            pending_heights.push_back(typed_res);
        else
            pending_heights.push_back(predict_height(x, z));
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_heights.size() != 0)
            @(posedge clk);
        // Loads give no result but may still be on their way to the store.
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            hbs_pkg::REG_ORIGIN_X:    org_x = data;
            hbs_pkg::REG_ORIGIN_Z:    org_z = data;
            hbs_pkg::REG_EXTENT:      side_len = data[30:0];
            hbs_pkg::REG_INV_SPACING: inv_spc = data;
            hbs_pkg::REG_CELLS:       cell_cnt = data[5:0];
            hbs_pkg::REG_SCALE:       h_scale = data;
            hbs_pkg::REG_OFFSET:      h_offset = data;
            default:                  ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] ox, input logic [31:0] oz, input logic [31:0] ext,
                             input logic [31:0] inv, input logic [31:0] cells,
                             input logic [31:0] scl, input logic [31:0] ofs);
        write_reg(hbs_pkg::REG_ORIGIN_X, ox);
        write_reg(hbs_pkg::REG_ORIGIN_Z, oz);
        write_reg(hbs_pkg::REG_EXTENT, ext);
        write_reg(hbs_pkg::REG_INV_SPACING, inv);
        write_reg(hbs_pkg::REG_CELLS, cells);
        write_reg(hbs_pkg::REG_SCALE, scl);
        write_reg(hbs_pkg::REG_OFFSET, ofs);
        cfg_valid <= 1'b0;
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        height_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_heights.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result: height %h in_bounds %b", height, in_bounds);
            end
            else
            begin
                want = pending_heights.pop_front();
                if (height !== want.height || in_bounds !== want.inb)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: expected height %h in_bounds %b, got %h %b",
                                 want.height, want.inb, height, in_bounds);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_left <= 400;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_pct);
    end

    initial
    begin
        stim_row_t          rows [$];
        stim_row_t          row;
        height_result_t     none;
        logic [31:0]        ox, oz, ext, inv, cells, scl, ofs, x, z;
        longint unsigned    span;
        int                 sel;

        none.height = '0;
        none.inb = 1'b0;
        org_x = '0;
        org_z = '0;
        side_len = '0;
        inv_spc = hbs_pkg::INV_SPC_RESET;
        cell_cnt = hbs_pkg::CELLS_RESET;
        h_scale = '0;
        h_offset = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every entry that a grid can reach so no query reads an unwritten sample.
        for (int i = 0; i < FILL_DEPTH; i++)
            send_request(hbs_pkg::REQ_LOAD, 12'(i), 16'($urandom_range(16'hFFFF)),
                         '0, '0, 0, none);

        // Directed part on a 4 x 4 grid with unit spacing and unit scale.
        drain_pipeline();
        write_all(32'h0, 32'h0, 32'h0004_0000, 32'h0001_0000, 32'd4, 32'h0100_0000, 32'h0);
        rows = '{
            '{hbs_pkg::REQ_LOAD,  12'd0,    16'hFFFF, 32'h0, 32'h0, 0, 32'h0, 1'b0},
            '{hbs_pkg::REQ_LOAD,  12'd24,   16'h1234, 32'h0, 32'h0, 0, 32'h0, 1'b0},
            '{hbs_pkg::REQ_LOAD,  12'd4095, 16'hFFFF, 32'h0, 32'h0, 0, 32'h0, 1'b0},
            '{hbs_pkg::REQ_LOAD,  12'd1,    16'h0000, 32'h0, 32'h0, 0, 32'h0, 1'b0},
            // A full-scale corner saturates at the positive limit.
            '{hbs_pkg::REQ_QUERY, 12'd0, 16'h0, 32'h0, 32'h0, 1, 32'h7FFF_FFFF, 1'b1},
            // Exactly on the far corner: clamped into the last cell.
            '{hbs_pkg::REQ_QUERY, 12'd0, 16'h0, 32'h0004_0000, 32'h0004_0000, 1,
              32'h1234_0000, 1'b1},
            '{hbs_pkg::REQ_QUERY, 12'd0, 16'h0, 32'hFFFF_FFFF, 32'h0, 1, 32'h0, 1'b0},
            '{hbs_pkg::REQ_QUERY, 12'd0, 16'h0, 32'h0, 32'hFFFF_FFFF, 1, 32'h0, 1'b0},
            '{hbs_pkg::REQ_QUERY, 12'd0, 16'h0, 32'h0004_0001, 32'h0, 1, 32'h0, 1'b0},
            '{hbs_pkg::REQ_QUERY, 12'd0, 16'h0, 32'h0, 32'h0004_0001, 1, 32'h0, 1'b0},
            '{hbs_pkg::REQ_QUERY, 12'd0, 16'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h0, 1'b0},
            '{hbs_pkg::REQ_QUERY, 12'd0, 16'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h0, 1'b0},
            '{hbs_pkg::REQ_QUERY, 12'd0, 16'h0, 32'h0000_8000, 32'h0000_8000, 0, 32'h0, 1'b0},
            '{hbs_pkg::REQ_QUERY, 12'd0, 16'h0, 32'h0001_8000, 32'h0002_C000, 0, 32'h0, 1'b0},
            '{hbs_pkg::REQ_QUERY, 12'd0, 16'h0, 32'h0000_FFFF, 32'h0003_FFFF, 0, 32'h0, 1'b0},
            '{hbs_pkg::REQ_QUERY, 12'd0, 16'h0, 32'h0004_0000, 32'h0, 0, 32'h0, 1'b0}
        };
        foreach (rows[i])
        begin
            row = rows[i];
            none.height = row.height;
            none.inb = row.inb;
            send_request(row.kind, row.idx, row.val, row.x, row.z, row.typed, none);
        end

        for (int ph = 0; ph < 10; ph++)
        begin
            drain_pipeline();
            cells = $urandom_range(1, RAND_CELLS_MAX);
            inv = $urandom_range(32'h4000, 32'h40000);
            ext = ((longint'(cells) << 32) / inv) & 32'h7FFF_FFFF;
            ox = $urandom;
            oz = $urandom;
            scl = $urandom;
            ofs = $urandom;
            case (ph)
                1: cells = 32'd0;
                2: begin ext = 32'h0; ox = 32'h8000_0000; oz = 32'h7FFF_FFFF; end
                3: begin ext = 32'h7FFF_FFFF; inv = 32'hFFFF_FFFF; ox = 32'h8000_0000;
                         oz = 32'h8000_0000; end
                4: inv = 32'h0;
                5: begin scl = 32'hFFFF_FFFF; ofs = 32'h7FFF_FFFF; cells = RAND_CELLS_MAX; end
                6: begin scl = 32'h0; ofs = 32'h8000_0000; end
                7: begin ox = 32'h7FFF_FFFF - ext; oz = 32'h0; end
                default: ;
            endcase
            write_all(ox, oz, ext, inv, cells, scl, ofs);
            case (ph % 4)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 46; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 46; end
                default: begin send_pct = 10; recv_pct = 10; end
            endcase
            if (ph == 4)
                hold_req++;
            for (int n = 0; n < 100; n++)
            begin
                sel = $urandom_range(99);
                span = side_len;
                x = org_x + (($urandom_range(9) == 0) ? span : $urandom_range(side_len));
                z = org_z + (($urandom_range(9) == 0) ? span : $urandom_range(side_len));
                if (sel < 20)
                    send_request(hbs_pkg::REQ_LOAD, 12'($urandom), 16'($urandom),
                                 $urandom, $urandom, 0, none);
                else if (sel < 30)
                    send_request(hbs_pkg::REQ_QUERY, 12'($urandom), 16'($urandom),
                                 $urandom, $urandom, 0, none);
                else
                    send_request(hbs_pkg::REQ_QUERY, 12'($urandom), 16'($urandom),
                                 x, z, 0, none);
            end
        end

        in_valid <= 1'b0;
        while (pending_heights.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_cnt == 0 && pending_heights.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/hbs_pkg.sv
hw/rtl/hbs_ram.sv
hw/rtl/hbs_front.sv
hw/rtl/hbs_back.sv
hw/rtl/heightfield_bilinear_sampler.sv
test/heightfield_bilinear_sampler_test.sv
